// ----- rtl/mmbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mmbd_pkg;

  typedef enum logic [2:0] {
    MODE_RD_B = 3'd0,
    MODE_RD_H = 3'd1,
    MODE_RD_W = 3'd2,
    MODE_WR_B = 3'd3,
    MODE_WR_H = 3'd4,
    MODE_WR_W = 3'd5,
    MODE_NOP6 = 3'd6,
    MODE_NOP7 = 3'd7
  } mode_t;

  localparam logic [2:0] CFG_DATA_BASE = 3'd0;
  localparam logic [2:0] CFG_STACK_TOP = 3'd1;
  localparam logic [2:0] CFG_TEXT_BASE = 3'd2;
  localparam logic [2:0] CFG_TEXT_END  = 3'd3;
  localparam logic [2:0] CFG_KEYPAD    = 3'd4;
  localparam logic [2:0] CFG_TIMER     = 3'd5;

  localparam logic [31:0] RST_DATA_BASE = 32'd268500992;
  localparam logic [31:0] RST_STACK_TOP = 32'd2147479551;
  localparam logic [31:0] RST_TEXT_BASE = 32'd536870912;
  localparam logic [31:0] RST_TEXT_END  = 32'd536875711;
  localparam logic [31:0] RST_KEYPAD    = 32'd805306368;
  localparam logic [31:0] RST_TIMER     = 32'd805306372;

  localparam logic [3:0] BYTE_FG = 4'hF;
  localparam logic [3:0] BYTE_BG = 4'h0;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [15:0] keypad_state;
    logic [31:0] timer_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        cell_write;
    logic [4:0]  cell_row;
    logic [6:0]  cell_col;
    logic [7:0]  cell_char;
    logic [3:0]  cell_fg;
    logic [3:0]  cell_bg;
    logic        last;
  } out_item_t;

  // Region selected for a memory access.
  typedef enum logic [3:0] {
    RG_NONE  = 4'b0001,
    RG_RAM   = 4'b0010,
    RG_DATA  = 4'b0100,
    RG_STACK = 4'b1000
  } region_t;

  // Kind of work the back end does for one classified item.
  typedef enum logic [4:0] {
    OP_CONST = 5'b00001,  // value known in front: device read or empty result
    OP_READ  = 5'b00010,
    OP_WRITE = 5'b00100,
    OP_CELL  = 5'b01000,
    OP_CELL2 = 5'b10000
  } op_t;

  // Classified command, with a fixed 21-bit region offset.
  typedef struct packed {
    op_t         op;
    region_t     region;
    logic [20:0] offset;
    logic [2:0]  nbytes;
    logic [31:0] value;
    logic        c0_ok;
    logic [4:0]  c0_row;
    logic [6:0]  c0_col;
    logic        c1_ok;
    logic [4:0]  c1_row;
    logic [6:0]  c1_col;
    logic        is_byte;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/memory_map_bus_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Memory-mapped data bus decoder. An access beat enters through in_push/in_full
// and yields one or two result beats on out_pop/out_empty. The front end
// registers the beat and then classifies it (device register, RAM region,
// text window); text window writes go on to find the cell row (reciprocal
// multiply) and then the column (multiply-subtract). The back end performs
// memory accesses on byte-wide memories: a read passes through a request
// state and a data state for each byte, a write through a write state for
// each byte, and then the result is emitted. The front end takes a new beat
// only once the back end has taken the previous command; a full two-entry
// result queue stalls the back end. After reset a clearing sweep over
// max(RAM_BYTES, DATA_BYTES, STACK_BYTES) addresses zeroes the memories
// before the first access is serviced. Configuration writes through
// cfg_valid/cfg_ready are always taken, but they belong in times when no
// access is in flight, since the front end reads the registers while it
// classifies a beat.
module memory_map_bus_decoder_top #(
  parameter int RAM_BYTES   = 16384,
  parameter int DATA_BYTES  = 16384,
  parameter int STACK_BYTES = 4096,
  parameter int TEXT_COLS   = 80,
  parameter int TEXT_ROWS   = 30
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_push,
  output logic                     in_full,
  input  wire mmbd_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire                      out_pop,
  output mmbd_pkg::out_item_t      out_item,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [2:0]                cfg_index,
  input  wire [31:0]               cfg_data
);
  logic [31:0] data_base_r, stack_top_r, text_base_r, text_end_r, keypad_r, timer_r;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r <= mmbd_pkg::RST_DATA_BASE;
      stack_top_r <= mmbd_pkg::RST_STACK_TOP;
      text_base_r <= mmbd_pkg::RST_TEXT_BASE;
      text_end_r  <= mmbd_pkg::RST_TEXT_END;
      keypad_r    <= mmbd_pkg::RST_KEYPAD;
      timer_r     <= mmbd_pkg::RST_TIMER;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mmbd_pkg::CFG_DATA_BASE: data_base_r <= cfg_data;
        mmbd_pkg::CFG_STACK_TOP: stack_top_r <= cfg_data;
        mmbd_pkg::CFG_TEXT_BASE: text_base_r <= cfg_data;
        mmbd_pkg::CFG_TEXT_END:  text_end_r  <= cfg_data;
        mmbd_pkg::CFG_KEYPAD:    keypad_r    <= cfg_data;
        mmbd_pkg::CFG_TIMER:     timer_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic in_ready, cmd_valid, cmd_ready, res_valid, res_ready;
  mmbd_pkg::cmd_t      cmd;
  mmbd_pkg::out_item_t res;

  assign in_full = !in_ready;

  mmbd_front #(
    .RAM_BYTES(RAM_BYTES), .DATA_BYTES(DATA_BYTES), .STACK_BYTES(STACK_BYTES),
    .TEXT_COLS(TEXT_COLS), .TEXT_ROWS(TEXT_ROWS)
  ) u_front (
    .clk, .rst_n,
    .in_valid(in_push), .in_ready, .in_item,
    .data_base(data_base_r), .stack_top(stack_top_r),
    .text_base(text_base_r), .text_end(text_end_r),
    .keypad_address(keypad_r), .timer_address(timer_r),
    .cmd_valid, .cmd_ready, .cmd
  );

  mmbd_back #(
    .RAM_BYTES(RAM_BYTES), .DATA_BYTES(DATA_BYTES), .STACK_BYTES(STACK_BYTES)
  ) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .res_valid, .res_ready, .res
  );

  mmbd_outq u_outq (
    .clk, .rst_n,
    .wr_valid(res_valid), .wr_ready(res_ready), .wr_item(res),
    .empty(out_empty), .pop(out_pop), .rd_item(out_item)
  );
endmodule
`default_nettype wire

// ----- rtl/mmbd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mmbd_front #(
  parameter int RAM_BYTES   = 16384,
  parameter int DATA_BYTES  = 16384,
  parameter int STACK_BYTES = 4096,
  parameter int TEXT_COLS   = 80,
  parameter int TEXT_ROWS   = 30
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire mmbd_pkg::in_item_t  in_item,
  input  wire [31:0]               data_base,
  input  wire [31:0]               stack_top,
  input  wire [31:0]               text_base,
  input  wire [31:0]               text_end,
  input  wire [31:0]               keypad_address,
  input  wire [31:0]               timer_address,
  output logic                     cmd_valid,
  input  wire                      cmd_ready,
  output mmbd_pkg::cmd_t           cmd
);
  localparam logic [32:0] WIN_BYTES = 33'(TEXT_COLS * TEXT_ROWS * 2);
  // 2^32 / TEXT_COLS rounded up. Multiplying a cell index below 2^17 by it and
  // keeping bits 32 and up of the product gives the exact row.
  localparam logic [32:0] COL_RECIP =
    33'(((64'd1 << 32) + 64'(TEXT_COLS) - 64'd1) / 64'(TEXT_COLS));

  // Stage 1 registers the item; stage 2 classifies. For text window writes
  // the row comes from a reciprocal multiply in state S_DIV and the column
  // from a multiply-subtract in state S_COL after it.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_COL  = 4'b0100,
    S_OUT  = 4'b1000
  } st_t;

  st_t                st_r, st_nxt;
  mmbd_pkg::in_item_t it_r;
  mmbd_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [32:0]        rem0_r, rem0_nxt, rem1_r, rem1_nxt;
  logic [16:0]        row0_r, row0_nxt, row1_r, row1_nxt;
  logic               hold_r, hold_nxt;

  logic [32:0] a33, off, db_end, st_lo, idx0, idx1;
  logic        in_win, in_win2, ram_hit, data_hit, stk_hit;
  logic [2:0]  nb;
  logic [31:0] msk;
  logic [49:0] prod0, prod1;
  logic [16:0] col0, col1;

  always_comb begin
    a33    = {1'b0, it_r.address};
    off    = a33 - {1'b0, text_base};
    db_end = {1'b0, data_base} + 33'(DATA_BYTES);
    st_lo  = {1'b0, stack_top} + 33'd1;
    in_win  = (a33 >= {1'b0, text_base}) && (a33 <= {1'b0, text_end});
    in_win2 = ((a33 + 33'd2) >= {1'b0, text_base}) && ((a33 + 33'd2) <= {1'b0, text_end});
    ram_hit  = a33 < 33'(RAM_BYTES);
    data_hit = (a33 >= {1'b0, data_base}) && (a33 < db_end);
    stk_hit  = (a33 <= {1'b0, stack_top}) && ((a33 + 33'(STACK_BYTES)) >= st_lo);
    idx0 = {1'b0, off[32:1]};
    idx1 = idx0 + 33'd1;
    prod0 = 50'(rem0_r[16:0]) * 50'(COL_RECIP);
    prod1 = 50'(rem1_r[16:0]) * 50'(COL_RECIP);
    col0  = rem0_r[16:0] - row0_r * 17'(TEXT_COLS);
    col1  = rem1_r[16:0] - row1_r * 17'(TEXT_COLS);
    unique case (mmbd_pkg::mode_t'(it_r.mode))
      mmbd_pkg::MODE_RD_B, mmbd_pkg::MODE_WR_B: nb = 3'd1;
      mmbd_pkg::MODE_RD_H, mmbd_pkg::MODE_WR_H: nb = 3'd2;
      default:                                   nb = 3'd4;
    endcase
    unique case (nb)
      3'd1:    msk = 32'h0000_00FF;
      3'd2:    msk = 32'h0000_FFFF;
      default: msk = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    cmd_nxt  = cmd_r;
    rem0_nxt = rem0_r;
    rem1_nxt = rem1_r;
    row0_nxt = row0_r;
    row1_nxt = row1_r;
    hold_nxt = hold_r;
    in_ready = (st_r == S_IDLE) && !hold_r;
    cmd_valid = (st_r == S_OUT);
    unique case (st_r)
      S_IDLE: begin
        if (hold_r) begin
          hold_nxt = 1'b0;
          cmd_nxt  = '0;
          cmd_nxt.nbytes = nb;
          cmd_nxt.is_byte = (nb == 3'd1);
          cmd_nxt.region = mmbd_pkg::RG_NONE;
          if (ram_hit) begin
            cmd_nxt.region = mmbd_pkg::RG_RAM;
            cmd_nxt.offset = 21'(a33);
          end else if (data_hit) begin
            cmd_nxt.region = mmbd_pkg::RG_DATA;
            cmd_nxt.offset = 21'(a33 - {1'b0, data_base});
          end else if (stk_hit) begin
            cmd_nxt.region = mmbd_pkg::RG_STACK;
            cmd_nxt.offset = 21'(a33 + 33'(STACK_BYTES) - st_lo);
          end
          cmd_nxt.op = mmbd_pkg::OP_CONST;
          st_nxt = S_OUT;
          if (mmbd_pkg::mode_t'(it_r.mode) <= mmbd_pkg::MODE_RD_W) begin
            if (it_r.address == keypad_address) begin
              cmd_nxt.value = {16'd0, it_r.keypad_state} & msk;
            end else if (it_r.address == timer_address) begin
              cmd_nxt.value = it_r.timer_value & msk;
            end else begin
              cmd_nxt.op = mmbd_pkg::OP_READ;
            end
          end else if (mmbd_pkg::mode_t'(it_r.mode) <= mmbd_pkg::MODE_WR_W) begin
            if (in_win) begin
              cmd_nxt.value = it_r.write_data;
              cmd_nxt.c0_ok = (off < WIN_BYTES) && !off[0];
              cmd_nxt.c1_ok = (nb == 3'd4) && in_win2 && ((off + 33'd2) < WIN_BYTES)
                              && !off[0];
              cmd_nxt.op = (nb == 3'd4) ? mmbd_pkg::OP_CELL2 : mmbd_pkg::OP_CELL;
              rem0_nxt = idx0;
              rem1_nxt = idx1;
              st_nxt = S_DIV;
            end else begin
              cmd_nxt.op    = mmbd_pkg::OP_WRITE;
              cmd_nxt.value = it_r.write_data;
            end
          end
        end else if (in_valid) begin
          hold_nxt = 1'b1;
        end
      end
      S_DIV: begin
        row0_nxt = prod0[48:32];
        row1_nxt = prod1[48:32];
        st_nxt   = S_COL;
      end
      S_COL: begin
        cmd_nxt.c0_row = row0_r[4:0];
        cmd_nxt.c0_col = col0[6:0];
        cmd_nxt.c1_row = row1_r[4:0];
        cmd_nxt.c1_col = col1[6:0];
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (cmd_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      hold_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      hold_r <= hold_nxt;
    end
    if (in_ready && in_valid) it_r <= in_item;
    cmd_r  <= cmd_nxt;
    rem0_r <= rem0_nxt;
    rem1_r <= rem1_nxt;
    row0_r <= row0_nxt;
    row1_r <= row1_nxt;
  end

  assign cmd = cmd_r;
endmodule
`default_nettype wire

// ----- rtl/mmbd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mmbd_back #(
  parameter int RAM_BYTES   = 16384,
  parameter int DATA_BYTES  = 16384,
  parameter int STACK_BYTES = 4096
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cmd_valid,
  output logic                    cmd_ready,
  input  wire mmbd_pkg::cmd_t     cmd,
  output logic                    res_valid,
  input  wire                     res_ready,
  output mmbd_pkg::out_item_t     res
);
  localparam int RA = (RAM_BYTES   > 1) ? $clog2(RAM_BYTES)   : 1;
  localparam int DA = (DATA_BYTES  > 1) ? $clog2(DATA_BYTES)  : 1;
  localparam int SA = (STACK_BYTES > 1) ? $clog2(STACK_BYTES) : 1;
  localparam int MAXB = (RAM_BYTES > DATA_BYTES)
                        ? ((RAM_BYTES > STACK_BYTES) ? RAM_BYTES : STACK_BYTES)
                        : ((DATA_BYTES > STACK_BYTES) ? DATA_BYTES : STACK_BYTES);
  localparam int CA = $clog2(MAXB + 1);

  // A memory port is accessed once per byte of the access; a new command is
  // taken only in B_IDLE. A clearing sweep runs through all memories after reset.
  typedef enum logic [5:0] {
    B_CLR  = 6'b000001,
    B_IDLE = 6'b000010,
    B_RREQ = 6'b000100,
    B_RDAT = 6'b001000,
    B_WR   = 6'b010000,
    B_EMIT = 6'b100000
  } bst_t;

  logic [7:0] ram_m [RAM_BYTES];
  logic [7:0] dat_m [DATA_BYTES];
  logic [7:0] stk_m [STACK_BYTES];

  bst_t           st_r, st_nxt;
  mmbd_pkg::cmd_t c_r;
  logic [CA-1:0]  clr_r, clr_nxt;
  logic [2:0]     i_r, i_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic [1:0]     k_r, k_nxt;
  logic [7:0]     rd_q;
  logic           ovf_r, ovf_nxt;

  logic [CA:0]    pos;
  logic           pos_ok;
  logic           we_ram, we_dat, we_stk;
  logic [7:0]     wbyte;
  logic [CA-1:0]  waddr;

  always_comb begin
    pos = (CA+1)'(c_r.offset) + (CA+1)'(i_r);
    unique case (c_r.region)
      mmbd_pkg::RG_RAM:   pos_ok = pos < (CA+1)'(RAM_BYTES);
      mmbd_pkg::RG_DATA:  pos_ok = pos < (CA+1)'(DATA_BYTES);
      mmbd_pkg::RG_STACK: pos_ok = pos < (CA+1)'(STACK_BYTES);
      default:            pos_ok = 1'b0;
    endcase
    unique case (i_r[1:0])
      2'd0:    wbyte = c_r.value[7:0];
      2'd1:    wbyte = c_r.value[15:8];
      2'd2:    wbyte = c_r.value[23:16];
      default: wbyte = c_r.value[31:24];
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    i_nxt     = i_r;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    ovf_nxt   = ovf_r;
    cmd_ready = 1'b0;
    res_valid = 1'b0;
    we_ram = 1'b0;
    we_dat = 1'b0;
    we_stk = 1'b0;
    waddr  = CA'(pos);
    res    = '0;
    unique case (st_r)
      B_CLR: begin
        waddr  = clr_r;
        we_ram = clr_r < CA'(RAM_BYTES);
        we_dat = clr_r < CA'(DATA_BYTES);
        we_stk = clr_r < CA'(STACK_BYTES);
        clr_nxt = clr_r + CA'(1);
        if (clr_r == CA'(MAXB - 1)) st_nxt = B_IDLE;
      end
      B_IDLE: begin
        cmd_ready = 1'b1;
        i_nxt   = '0;
        acc_nxt = '0;
        k_nxt   = '0;
        if (cmd_valid) begin
          unique case (cmd.op)
            mmbd_pkg::OP_READ:  st_nxt = B_RREQ;
            mmbd_pkg::OP_WRITE: st_nxt = B_WR;
            default:            st_nxt = B_EMIT;
          endcase
        end
      end
      B_RREQ: begin
        ovf_nxt = !pos_ok;
        st_nxt  = B_RDAT;
      end
      B_RDAT: begin
        if (!ovf_r) begin
          unique case (i_r[1:0])
            2'd0:    acc_nxt[7:0]   = rd_q;
            2'd1:    acc_nxt[15:8]  = rd_q;
            2'd2:    acc_nxt[23:16] = rd_q;
            default: acc_nxt[31:24] = rd_q;
          endcase
        end
        i_nxt = i_r + 3'd1;
        st_nxt = ((i_r + 3'd1) == c_r.nbytes) ? B_EMIT : B_RREQ;
      end
      B_WR: begin
        if (pos_ok) begin
          we_ram = (c_r.region == mmbd_pkg::RG_RAM);
          we_dat = (c_r.region == mmbd_pkg::RG_DATA);
          we_stk = (c_r.region == mmbd_pkg::RG_STACK);
        end
        i_nxt = i_r + 3'd1;
        if ((i_r + 3'd1) == c_r.nbytes) st_nxt = B_EMIT;
      end
      B_EMIT: begin
        res_valid = 1'b1;
        unique case (c_r.op)
          mmbd_pkg::OP_CONST: begin
            res.read_data = c_r.value;
            res.last = 1'b1;
          end
          mmbd_pkg::OP_READ: begin
            res.read_data = acc_r;
            res.last = 1'b1;
          end
          mmbd_pkg::OP_CELL, mmbd_pkg::OP_CELL2: begin
            // k_r counts cell results already delivered.
            if (k_r == 2'd0 && c_r.c0_ok) begin
              res.cell_write = 1'b1;
              res.cell_row  = c_r.c0_row;
              res.cell_col  = c_r.c0_col;
              res.cell_char = c_r.value[7:0];
              res.cell_fg   = c_r.is_byte ? mmbd_pkg::BYTE_FG : c_r.value[11:8];
              res.cell_bg   = c_r.is_byte ? mmbd_pkg::BYTE_BG : c_r.value[15:12];
              res.last      = !c_r.c1_ok;
            end else if (c_r.c1_ok && (k_r == 2'd1 || !c_r.c0_ok)) begin
              res.cell_write = 1'b1;
              res.cell_row  = c_r.c1_row;
              res.cell_col  = c_r.c1_col;
              res.cell_char = c_r.value[23:16];
              res.cell_fg   = c_r.value[27:24];
              res.cell_bg   = c_r.value[31:28];
              res.last      = 1'b1;
            end else begin
              res.last = 1'b1;
            end
          end
          default: res.last = 1'b1;
        endcase
        if (res_ready) begin
          k_nxt = k_r + 2'd1;
          if (res.last) st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_CLR;
      clr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
    end
    if (st_r == B_IDLE && cmd_valid) c_r <= cmd;
    i_r   <= i_nxt;
    acc_r <= acc_nxt;
    k_r   <= k_nxt;
    ovf_r <= ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_ram) ram_m[waddr[RA-1:0]] <= (st_r == B_CLR) ? 8'd0 : wbyte;
    if (we_dat) dat_m[waddr[DA-1:0]] <= (st_r == B_CLR) ? 8'd0 : wbyte;
    if (we_stk) stk_m[waddr[SA-1:0]] <= (st_r == B_CLR) ? 8'd0 : wbyte;
  end

  logic [7:0] q_ram, q_dat, q_stk;
  always_ff @(posedge clk) begin
    q_ram <= ram_m[pos[RA-1:0]];
    q_dat <= dat_m[pos[DA-1:0]];
    q_stk <= stk_m[pos[SA-1:0]];
  end

  always_comb begin
    unique case (c_r.region)
      mmbd_pkg::RG_RAM:   rd_q = q_ram;
      mmbd_pkg::RG_DATA:  rd_q = q_dat;
      mmbd_pkg::RG_STACK: rd_q = q_stk;
      default:            rd_q = 8'd0;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/mmbd_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mmbd_outq (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       wr_valid,
  output logic                      wr_ready,
  input  wire mmbd_pkg::out_item_t  wr_item,
  output logic                      empty,
  input  wire                       pop,
  output mmbd_pkg::out_item_t       rd_item
);
  // Two-entry result queue so the back end can finish while a beat waits.
  mmbd_pkg::out_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_w, do_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign do_w = wr_valid && wr_ready;
  assign do_r = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_w) wp_r <= !wp_r;
      if (do_r) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_w) - 2'(do_r);
    end
    if (do_w) mem_r[wp_r] <= wr_item;
  end
endmodule
`default_nettype wire
